// File: sv/life_like_automaton_step_defines.svh
// Assertion macros used by the automaton RTL.
// LLA_ASSERT is quiet while rst is high; LLA_ASSERT_ALWAYS also checks during reset.
`ifndef LIFE_LIKE_AUTOMATON_STEP_DEFINES_SVH
`define LIFE_LIKE_AUTOMATON_STEP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define LLA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define LLA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LLA_ASSERT(label, prop, msg)
`define LLA_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// File: sv/lla_pkg.sv
package lla_pkg;

  localparam int DEFAULT_MAX_COLUMNS = 64;
  localparam int DEFAULT_MAX_ROWS    = 64;

  localparam int ROW_PORT_W = 64;
  localparam int GEN_W      = 32;
  localparam int SIZE_W     = 7;
  localparam int RULE_W     = 9;
  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int NBR_W      = 4;

  // Command codes
  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_STEP  = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIRTH_MASK   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SURVIVE_MASK = 2'd3;

  localparam logic [SIZE_W-1:0] RESET_GRID_WIDTH   = 7'd40;
  localparam logic [SIZE_W-1:0] RESET_GRID_HEIGHT  = 7'd30;
  localparam logic [RULE_W-1:0] RESET_BIRTH_MASK   = 9'd8;
  localparam logic [RULE_W-1:0] RESET_SURVIVE_MASK = 9'd12;

  typedef struct packed {
    logic [RULE_W-1:0] birth;
    logic [RULE_W-1:0] survive;
  } rule_t;

endpackage

// File: sv/lla_cell.sv
// One row of the grid; advances to the neighbor slot on every shift.
module lla_cell #(
  parameter int COLS = lla_pkg::DEFAULT_MAX_COLUMNS
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            shift,
  input  logic [COLS-1:0] row_in,
  output logic [COLS-1:0] row_out
);

  logic [COLS-1:0] row;

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
    end else if (shift) begin
      row <= row_in;
    end
  end

  assign row_out = row;

endmodule

// File: sv/lla_rule.sv
// New row from a three-row window; columns outside the mask come out dead.
module lla_rule #(
  parameter int COLS = lla_pkg::DEFAULT_MAX_COLUMNS
) (
  input  lla_pkg::rule_t  rule_cfg,
  input  logic [COLS-1:0] col_mask,
  input  logic [COLS-1:0] row_up,
  input  logic [COLS-1:0] row_mid,
  input  logic [COLS-1:0] row_dn,
  output logic [COLS-1:0] row_new
);

  logic [COLS+1:0] up_pad;
  logic [COLS+1:0] mid_pad;
  logic [COLS+1:0] dn_pad;

  assign up_pad  = {1'b0, row_up, 1'b0};
  assign mid_pad = {1'b0, row_mid, 1'b0};
  assign dn_pad  = {1'b0, row_dn, 1'b0};

  for (genvar x = 0; x < COLS; x++) begin : g_col
    logic [lla_pkg::NBR_W-1:0]  nbr_count;
    logic [lla_pkg::RULE_W-1:0] rule_bits;

    // padded index x+1 is column x
    assign nbr_count = lla_pkg::NBR_W'(up_pad[x]) + lla_pkg::NBR_W'(up_pad[x+1])
                     + lla_pkg::NBR_W'(up_pad[x+2]) + lla_pkg::NBR_W'(mid_pad[x])
                     + lla_pkg::NBR_W'(mid_pad[x+2]) + lla_pkg::NBR_W'(dn_pad[x])
                     + lla_pkg::NBR_W'(dn_pad[x+1]) + lla_pkg::NBR_W'(dn_pad[x+2]);
    assign rule_bits = row_mid[x] ? rule_cfg.survive : rule_cfg.birth;
    assign row_new[x] = rule_bits[nbr_count] & col_mask[x];
  end

endmodule

// File: sv/life_like_automaton_step.sv
// Life-like cellular automaton (birth/survive rule) on a grid of one-bit cells.
// Item channel (item_valid / item_stall): cmd, row_index, row_bits. cmd write
// loads one row, masked to the configured width; step computes one generation
// with dead cells beyond the edges and no wrap; read returns one row.
// Result channel (result_valid / result_stall): row_data (the row on a read,
// zero otherwise) and generation_count after the command. One result per item.
// The grid sits in a circular chain of MAX_ROWS row cells. Every command rotates
// the chain once, one row per cycle. An accepted item passes through the
// rotation (S_RUN) and the final state (S_FINISH) into the result register;
// a new item is taken only once the block is idle again. The sweep length is
// set by the chain depth: a step sees rows y-1, y, y+1 as the head of the
// chain passes row y, and a read or write catches its row as it goes by.
// The result register parts the channels: the next transaction is taken while
// a result still waits, and a finished sweep holds in a final state while the
// receiver stalls with the previous result.
// Reset (rst, synchronous) clears all cells, the generation counter and the
// result valid, and loads width 40, height 30, rule B3/S23. Configuration writes
// (cfg_write, cfg_index, cfg_data) must be made only while idle; not enforced.
`include "life_like_automaton_step_defines.svh"

module life_like_automaton_step #(
  parameter int MAX_COLUMNS = lla_pkg::DEFAULT_MAX_COLUMNS,
  parameter int MAX_ROWS    = lla_pkg::DEFAULT_MAX_ROWS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [lla_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lla_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic [1:0]                        cmd,
  input  logic [5:0]                        row_index,
  input  logic [lla_pkg::ROW_PORT_W-1:0]    row_bits,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic [lla_pkg::ROW_PORT_W-1:0]    row_data,
  output logic [lla_pkg::GEN_W-1:0]         generation_count
);

  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int CMP_W = ((ROW_W > lla_pkg::SIZE_W) ? ROW_W : lla_pkg::SIZE_W) + 1;
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(MAX_ROWS - 1);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_RUN    = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t state;
  logic [ROW_W-1:0] sweep_row;
  logic [lla_pkg::GEN_W-1:0] generation_counter;

  // Configuration registers
  logic [lla_pkg::SIZE_W-1:0] grid_width;
  logic [lla_pkg::SIZE_W-1:0] grid_height;
  lla_pkg::rule_t rule_cfg;

  // Latched transaction
  lla_pkg::cmd_t cmd_q;
  logic [5:0] row_index_q;
  logic [MAX_COLUMNS-1:0] wr_bits;
  logic [MAX_COLUMNS-1:0] rd_row;
  logic [MAX_COLUMNS-1:0] prev_row;

  logic [MAX_COLUMNS-1:0] chain_q [MAX_ROWS];
  logic [MAX_COLUMNS-1:0] head_row;
  logic [MAX_COLUMNS-1:0] tail_row;
  logic [MAX_COLUMNS-1:0] col_mask;
  logic [MAX_COLUMNS-1:0] win_up;
  logic [MAX_COLUMNS-1:0] win_mid;
  logic [MAX_COLUMNS-1:0] win_dn;
  logic [MAX_COLUMNS-1:0] step_row;

  logic item_take;
  logic out_free;
  logic shift;
  logic row_live;
  logic dn_live;
  logic row_hit;

  assign item_stall = (state != S_IDLE);
  assign item_take  = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;
  assign shift      = (state == S_RUN);

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width       <= lla_pkg::RESET_GRID_WIDTH;
      grid_height      <= lla_pkg::RESET_GRID_HEIGHT;
      rule_cfg.birth   <= lla_pkg::RESET_BIRTH_MASK;
      rule_cfg.survive <= lla_pkg::RESET_SURVIVE_MASK;
    end else if (cfg_write) begin
      case (cfg_index)
        lla_pkg::REG_GRID_WIDTH:   grid_width       <= cfg_data[lla_pkg::SIZE_W-1:0];
        lla_pkg::REG_GRID_HEIGHT:  grid_height      <= cfg_data[lla_pkg::SIZE_W-1:0];
        lla_pkg::REG_BIRTH_MASK:   rule_cfg.birth   <= cfg_data;
        lla_pkg::REG_SURVIVE_MASK: rule_cfg.survive <= cfg_data;
        default: ;
      endcase
    end
  end

  // Columns at or beyond the width in use are dead
  for (genvar x = 0; x < MAX_COLUMNS; x++) begin : g_mask
    assign col_mask[x] = (lla_pkg::SIZE_W'(x) < grid_width);
  end

  // Chain of row cells: slot k takes slot k+1, the last slot takes the tail row
  for (genvar k = 0; k < MAX_ROWS; k++) begin : g_chain
    logic [MAX_COLUMNS-1:0] link_in;
    if (k == MAX_ROWS - 1) begin : g_tail
      assign link_in = tail_row;
    end else begin : g_link
      assign link_in = chain_q[k+1];
    end
    lla_cell #(.COLS(MAX_COLUMNS)) u_row (
      .clk     (clk),
      .rst     (rst),
      .shift   (shift),
      .row_in  (link_in),
      .row_out (chain_q[k])
    );
  end

  // Head slot holds row sweep_row; slot 1 still holds the old row below it
  assign head_row = chain_q[0];
  assign row_live = (CMP_W'(sweep_row) < CMP_W'(grid_height));
  assign dn_live  = (sweep_row != LAST_ROW)
                 && ((CMP_W'(sweep_row) + CMP_W'(1)) < CMP_W'(grid_height));
  assign row_hit  = row_live && (CMP_W'(sweep_row) == CMP_W'(row_index_q));

  assign win_up  = (sweep_row != '0) ? (prev_row & col_mask) : '0;
  assign win_mid = head_row & col_mask;
  assign win_dn  = dn_live ? (chain_q[1] & col_mask) : '0;

  lla_rule #(.COLS(MAX_COLUMNS)) u_rule (
    .rule_cfg (rule_cfg),
    .col_mask (col_mask),
    .row_up   (win_up),
    .row_mid  (win_mid),
    .row_dn   (win_dn),
    .row_new  (step_row)
  );

  // Row that goes back into the tail of the chain
  always_comb begin
    case (cmd_q)
      lla_pkg::CMD_STEP:  tail_row = row_live ? step_row : '0;
      lla_pkg::CMD_WRITE: tail_row = row_hit ? (wr_bits & col_mask) : head_row;
      default:            tail_row = head_row;
    endcase
  end

  // Sequencer: one full rotation per transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      sweep_row          <= '0;
      generation_counter <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (item_take) begin
            state     <= S_RUN;
            sweep_row <= '0;
            if (cmd == lla_pkg::CMD_STEP) begin
              generation_counter <= generation_counter + lla_pkg::GEN_W'(1);
            end
          end
        end
        S_RUN: begin
          sweep_row <= sweep_row + ROW_W'(1);
          if (sweep_row == LAST_ROW) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Transaction payload, previous row of the window, read capture
  always_ff @(posedge clk) begin
    if (item_take) begin
      cmd_q       <= lla_pkg::cmd_t'(cmd);
      row_index_q <= row_index;
      wr_bits     <= row_bits[MAX_COLUMNS-1:0];
      rd_row      <= '0;
    end else if (shift) begin
      prev_row <= head_row;
      if (row_hit && (cmd_q == lla_pkg::CMD_READ)) begin
        rd_row <= head_row & col_mask;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if ((state == S_FINISH) && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_FINISH) && out_free) begin
      row_data         <= lla_pkg::ROW_PORT_W'(rd_row);
      generation_count <= generation_counter;
    end
  end

  `LLA_ASSERT(a_step_advances_gen, (item_take && (cmd == lla_pkg::CMD_STEP)) |=> (generation_counter == $past(generation_counter) + 32'd1), "step did not advance the generation counter")
  `LLA_ASSERT(a_other_keeps_gen, (item_take && (cmd != lla_pkg::CMD_STEP)) |=> $stable(generation_counter), "generation counter moved without a step")
  `LLA_ASSERT(a_sweep_ends, ((state == S_RUN) && (sweep_row == LAST_ROW)) |=> (state == S_FINISH), "rotation did not end after the last row")
  `LLA_ASSERT(a_finish_loads, ((state == S_FINISH) && out_free) |=> (result_valid && (state == S_IDLE)), "finished sweep not moved to the result register")
  `LLA_ASSERT_ALWAYS(a_reset_clears_out, rst |=> (!result_valid && (state == S_IDLE)), "reset left a result or a busy sequencer")

endmodule
